// File: rtl/lwc_pkg.sv
// lwc_pkg: shared types, constants and register indexes for the LCD window
// clip and write unit. No dependencies.
`timescale 1ns / 1ps

package lwc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 64;
    localparam int M_FIELDS_W = 133;
    localparam int M_TDATA_W  = 136;

    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OP       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_WRITE_OP = 3'd6;

    localparam logic [14:0] RST_PANEL_WIDTH  = 15'd240;
    localparam logic [14:0] RST_PANEL_HEIGHT = 15'd320;
    localparam logic [15:0] RST_COLUMN_OFS   = 16'd0;
    localparam logic [15:0] RST_ROW_OFS      = 16'd0;
    localparam logic [7:0]  RST_COLUMN_OP    = 8'd42;
    localparam logic [7:0]  RST_ROW_OP       = 8'd43;
    localparam logic [7:0]  RST_MEM_WRITE_OP = 8'd44;

    localparam logic [2:0] PARAM_BYTES = 3'd4;
    localparam logic       KIND_CMD    = 1'b0;
    localparam logic       KIND_BURST  = 1'b1;

    typedef struct packed {
        logic [14:0] panel_width;
        logic [14:0] panel_height;
        logic [15:0] column_offset;
        logic [15:0] row_offset;
        logic [7:0]  column_set_opcode;
        logic [7:0]  row_set_opcode;
        logic [7:0]  memory_write_opcode;
    } cfg_t;

    typedef struct packed {
        logic [15:0] col_start;
        logic [15:0] col_end;
        logic [15:0] row_start;
        logic [15:0] row_end;
        logic [29:0] src_offset;
        logic [29:0] run_length;
        logic [14:0] run_count;
        logic [14:0] run_stride;
    } window_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  opcode;
        logic [2:0]  param_count;
        logic [7:0]  param0;
        logic [7:0]  param1;
        logic [7:0]  param2;
        logic [7:0]  param3;
        logic [29:0] src_offset;
        logic [29:0] run_length;
        logic [14:0] run_count;
        logic [14:0] run_stride;
        logic        last;
    } result_t;

    typedef enum logic [3:0] {
        STEP_COLUMN = 4'b0001,
        STEP_ROW    = 4'b0010,
        STEP_MEMWR  = 4'b0100,
        STEP_BURST  = 4'b1000
    } step_t;

endpackage

// File: rtl/lwc_regs.sv
// lwc_regs: configuration register file written through the cfg channel.
// Depends on lwc_pkg.
`timescale 1ns / 1ps

module lwc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lwc_pkg::CFG_DATA_W-1:0] cfg_data,
    output lwc_pkg::cfg_t                  cfg
);
    import lwc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PANEL_WIDTH:  cfg_next.panel_width         = cfg_data[14:0];
                REG_PANEL_HEIGHT: cfg_next.panel_height        = cfg_data[14:0];
                REG_COLUMN_OFS:   cfg_next.column_offset       = cfg_data;
                REG_ROW_OFS:      cfg_next.row_offset          = cfg_data;
                REG_COLUMN_OP:    cfg_next.column_set_opcode   = cfg_data[7:0];
                REG_ROW_OP:       cfg_next.row_set_opcode      = cfg_data[7:0];
                REG_MEM_WRITE_OP: cfg_next.memory_write_opcode = cfg_data[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width         <= RST_PANEL_WIDTH;
            cfg_reg.panel_height        <= RST_PANEL_HEIGHT;
            cfg_reg.column_offset       <= RST_COLUMN_OFS;
            cfg_reg.row_offset          <= RST_ROW_OFS;
            cfg_reg.column_set_opcode   <= RST_COLUMN_OP;
            cfg_reg.row_set_opcode      <= RST_ROW_OP;
            cfg_reg.memory_write_opcode <= RST_MEM_WRITE_OP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/lwc_front.sv
// lwc_front: accepts rectangles, clips them to the panel, drops empty ones,
// and computes addresses and burst geometry for the queue. Depends on lwc_pkg.
`timescale 1ns / 1ps

module lwc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  lwc_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  rect_x,
    input  logic signed [15:0]  rect_y,
    input  logic signed [15:0]  rect_w,
    input  logic signed [15:0]  rect_h,
    output logic                push,
    input  logic                push_ready,
    output lwc_pkg::window_t    push_data
);
    import lwc_pkg::*;

    logic signed [17:0] xe, ye, we, he, pw, ph;
    logic signed [17:0] x1, y1, w1, h1, w2, h2, skx, sky;
    logic               keep;
    logic               accept;

    logic        valid_reg, valid_next;
    logic [14:0] x_reg, y_reg, w_reg, h_reg, skip_x_reg, skip_y_reg, stride_reg;

    logic [15:0] col_start, row_start;
    logic [29:0] offset_prod, area_prod;
    logic        contiguous;

    always_comb
    begin
        xe = {{2{rect_x[15]}}, rect_x};
        ye = {{2{rect_y[15]}}, rect_y};
        we = {{2{rect_w[15]}}, rect_w};
        he = {{2{rect_h[15]}}, rect_h};
        pw = {3'b000, cfg.panel_width};
        ph = {3'b000, cfg.panel_height};

        if (rect_x < 0)
        begin
            skx = -xe;
            w1  = we + xe;
            x1  = '0;
        end
        else
        begin
            skx = '0;
            w1  = we;
            x1  = xe;
        end
        if (rect_y < 0)
        begin
            sky = -ye;
            h1  = he + ye;
            y1  = '0;
        end
        else
        begin
            sky = '0;
            h1  = he;
            y1  = ye;
        end

        w2 = (x1 + w1 > pw) ? pw - x1 : w1;
        h2 = (y1 + h1 > ph) ? ph - y1 : h1;

        keep = (rect_w > 0) && (rect_h > 0) && (w2 > 0) && (h2 > 0);
    end

    assign in_ready = !valid_reg || push_ready;
    assign accept   = in_valid && in_ready;
    assign push     = valid_reg && push_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = keep;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg      <= x1[14:0];
            y_reg      <= y1[14:0];
            w_reg      <= w2[14:0];
            h_reg      <= h2[14:0];
            skip_x_reg <= skx[14:0];
            skip_y_reg <= sky[14:0];
            stride_reg <= rect_w[14:0];
        end
    end

    always_comb
    begin
        col_start   = {1'b0, x_reg} + cfg.column_offset;
        row_start   = {1'b0, y_reg} + cfg.row_offset;
        offset_prod = {15'd0, skip_y_reg} * {15'd0, stride_reg};
        area_prod   = {15'd0, w_reg} * {15'd0, h_reg};
        contiguous  = (w_reg == stride_reg);

        push_data.col_start  = col_start;
        push_data.col_end    = col_start + {1'b0, w_reg} - 16'd1;
        push_data.row_start  = row_start;
        push_data.row_end    = row_start + {1'b0, h_reg} - 16'd1;
        push_data.src_offset = offset_prod + {15'd0, skip_x_reg};
        push_data.run_length = contiguous ? area_prod : {15'd0, w_reg};
        push_data.run_count  = contiguous ? 15'd1 : h_reg;
        push_data.run_stride = stride_reg;
    end

endmodule

// File: rtl/lwc_queue.sv
// lwc_queue: small FIFO of clipped windows between front and back.
// Depends on lwc_pkg.
`timescale 1ns / 1ps

module lwc_queue #(
    parameter int DEPTH = lwc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             push_ready,
    input  lwc_pkg::window_t push_data,
    input  logic             pop,
    output logic             pop_valid,
    output lwc_pkg::window_t pop_data
);
    import lwc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    window_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/lwc_back.sv
// lwc_back: sequencer that turns one queued window into the column-set,
// row-set, memory-write and burst results. Depends on lwc_pkg.
`timescale 1ns / 1ps

module lwc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lwc_pkg::cfg_t    cfg,
    input  logic             win_valid,
    output logic             win_pop,
    input  lwc_pkg::window_t win,
    output logic             out_valid,
    input  logic             out_ready,
    output lwc_pkg::result_t out_data
);
    import lwc_pkg::*;

    step_t   step_reg, step_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, result;
    logic    load;

    assign load      = (!out_valid_reg || out_ready) && win_valid;
    assign win_pop   = load && (step_reg == STEP_BURST);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        result    = '0;
        step_next = step_reg;
        case (step_reg)
            STEP_COLUMN:
            begin
                result.kind        = KIND_CMD;
                result.opcode      = cfg.column_set_opcode;
                result.param_count = PARAM_BYTES;
                result.param0      = win.col_start[15:8];
                result.param1      = win.col_start[7:0];
                result.param2      = win.col_end[15:8];
                result.param3      = win.col_end[7:0];
                step_next          = STEP_ROW;
            end
            STEP_ROW:
            begin
                result.kind        = KIND_CMD;
                result.opcode      = cfg.row_set_opcode;
                result.param_count = PARAM_BYTES;
                result.param0      = win.row_start[15:8];
                result.param1      = win.row_start[7:0];
                result.param2      = win.row_end[15:8];
                result.param3      = win.row_end[7:0];
                step_next          = STEP_MEMWR;
            end
            STEP_MEMWR:
            begin
                result.kind   = KIND_CMD;
                result.opcode = cfg.memory_write_opcode;
                step_next     = STEP_BURST;
            end
            STEP_BURST:
            begin
                result.kind       = KIND_BURST;
                result.src_offset = win.src_offset;
                result.run_length = win.run_length;
                result.run_count  = win.run_count;
                result.run_stride = win.run_stride;
                result.last       = 1'b1;
                step_next         = STEP_COLUMN;
            end
            default:
            begin
                step_next = STEP_COLUMN;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_COLUMN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
                step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= result;
    end

endmodule

// File: rtl/lcd_window_clip_and_write_unit.sv
// Top level of the LCD window clip and write unit: register file, clipping
// front, window queue and command sequencer. Depends on lwc_pkg, lwc_regs,
// lwc_front, lwc_queue, lwc_back.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    s_tdata: rect_x, rect_y, rect_w, rect_h
//   m_*      out  m_tvalid/m_tready    m_tdata, m_tuser (kind), m_tlast (last)
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A rectangle is clipped in the cycle it is taken; the front registers it
// and pushes its addresses and burst geometry into the queue. The sequencer
// emits one result per cycle while a window is queued and m_tready is high,
// four per visible rectangle; the single result port sets the sustained rate.
// The first result passes the front register, the queue and the output register.
// Rectangles that clip to nothing give no result. Reset loads the register
// defaults and empties the queue. A stall on m_tready holds the output
// register; the queue then fills and s_tready drops.
`timescale 1ns / 1ps

module lcd_window_clip_and_write_unit #(
    parameter int QUEUE_DEPTH = lwc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rect_x[15:0], rect_y[31:16], rect_w[47:32], rect_h[63:48]
    input  logic [lwc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // opcode[7:0], param_count[10:8], param0[18:11], param1[26:19],
    // param2[34:27], param3[42:35], src_offset[72:43], run_length[102:73],
    // run_count[117:103], run_stride[132:118], zero[135:133]
    output logic [lwc_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind[0]
    output logic                           m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lwc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lwc_pkg::*;

    cfg_t    cfg;
    window_t push_data, pop_data;
    result_t res;
    logic    push, push_ready, pop, pop_valid;

    lwc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lwc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .rect_x     ($signed(s_tdata[15:0])),
        .rect_y     ($signed(s_tdata[31:16])),
        .rect_w     ($signed(s_tdata[47:32])),
        .rect_h     ($signed(s_tdata[63:48])),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lwc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    lwc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .win_valid (pop_valid),
        .win_pop   (pop),
        .win       (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                      res.run_stride, res.run_count, res.run_length, res.src_offset,
                      res.param3, res.param2, res.param1, res.param0,
                      res.param_count, res.opcode};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
